// ----- hdl/distance_announcement_trigger_unit_assert.svh -----
// Assertion macros used by the distance announcement trigger RTL.
`ifndef DISTANCE_ANNOUNCEMENT_TRIGGER_UNIT_ASSERT_SVH
`define DISTANCE_ANNOUNCEMENT_TRIGGER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DAT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dat assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dat assertion failed");

`endif

// ----- hdl/dat_pkg.sv -----
// Types, codes and constants of the distance announcement trigger.
package dat_pkg;

	// Width of the stored instruction index.
	localparam int INDEX_BITS = 16;

	// Item function codes.
	localparam logic [1:0] FUNC_UPDATE  = 2'd0;
	localparam logic [1:0] FUNC_REROUTE = 2'd1;
	localparam logic [1:0] FUNC_RESET   = 2'd2;

	// Navigation status codes.
	localparam logic [1:0] STATUS_ON_ROUTE  = 2'd0;
	localparam logic [1:0] STATUS_OFF_ROUTE = 2'd1;
	localparam logic [1:0] STATUS_ARRIVED   = 2'd2;

	// Announcement kinds.
	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_ARRIVED  = 3'd1;
	localparam logic [2:0] KIND_OFFROUTE = 3'd2;
	localparam logic [2:0] KIND_REROUTE  = 3'd3;
	localparam logic [2:0] KIND_DIST     = 3'd4;
	localparam logic [2:0] KIND_NOW      = 3'd5;

	// Speed clamp in cm/s and threshold limits in cm.
	localparam logic [12:0] SPEED_MAX = 13'd6000;
	localparam logic [16:0] FAR_MIN   = 17'd20000;
	localparam logic [16:0] FAR_MAX   = 17'd60000;
	localparam logic [16:0] NEAR_MIN  = 17'd6000;
	localparam logic [16:0] NEAR_MAX  = 17'd18000;
	localparam logic [16:0] NOW_MIN   = 17'd2000;
	localparam logic [16:0] NOW_MAX   = 17'd4500;

	// Distance rounding: 10 m steps below 100 m, 50 m steps above.
	localparam logic [23:0] FINE_LIMIT = 24'd10000;
	localparam logic [23:0] FINE_HALF  = 24'd500;
	localparam logic [23:0] COARSE_HALF = 24'd2500;
	localparam int          RND_SHIFT  = 35;
	// ceil(2^35 / 1000) and ceil(2^35 / 5000); exact for all 24-bit sums
	localparam logic [25:0] RECIP_FINE   = 26'd34359739;
	localparam logic [25:0] RECIP_COARSE = 26'd6871948;
	localparam logic [16:0] FINE_METRES   = 17'd10;
	localparam logic [16:0] COARSE_METRES = 17'd50;

	typedef logic [INDEX_BITS-1:0] dat_index_t;

	// One input item.
	typedef struct packed {
		logic [1:0]         func;
		logic               nav_valid;
		logic [1:0]         nav_status;
		logic               next_found;
		logic               next_is_arrive;
		logic [15:0]        next_index;
		logic signed [23:0] distance_cm;
		logic signed [15:0] speed_cmps;
		logic               speaker_ready;
	} dat_in_t;

	// One result item.
	typedef struct packed {
		logic        spoke;
		logic [2:0]  kind;
		logic [16:0] rounded_metres;
		logic [15:0] announced_index;
		logic        stop_speech;
	} dat_out_t;

	// Announcement state.
	typedef struct packed {
		logic       initial_done;
		logic       have_current;
		dat_index_t current_index;
		logic       far_done;
		logic       near_done;
		logic       now_done;
		logic       offroute_done;
		logic       arrival_done;
	} dat_state_t;

	localparam dat_state_t STATE_CLEAR = '{
		initial_done:  1'b0,
		have_current:  1'b0,
		current_index: '1,
		far_done:      1'b0,
		near_done:     1'b0,
		now_done:      1'b0,
		offroute_done: 1'b0,
		arrival_done:  1'b0
	};

	// 16-bit field index to stored index width.
	function automatic dat_index_t to_index(input logic [15:0] v);
		logic [INDEX_BITS+15:0] ext;
		ext = {{INDEX_BITS{1'b0}}, v};
		return ext[INDEX_BITS-1:0];
	endfunction

	// Stored index back to the 16-bit result field.
	function automatic logic [15:0] from_index(input dat_index_t v);
		logic [INDEX_BITS+15:0] ext;
		ext = {16'd0, v};
		return ext[15:0];
	endfunction

endpackage

// ----- hdl/dat_channels.sv -----
// Valid/ready channel interfaces for input items and results.
interface dat_in_if import dat_pkg::*; ();
	logic    valid;
	logic    ready;
	dat_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dat_out_if import dat_pkg::*; ();
	logic     valid;
	logic     ready;
	dat_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/dat_decide.sv -----
// Announcement decision: thresholds, distance rounding, flag update.
module dat_decide import dat_pkg::*; (
	input  dat_in_t    item,
	input  dat_state_t state_cur,
	input  logic       enable,
	output dat_out_t   result,
	output dat_state_t state_nxt
);

	logic [12:0] speed;
	logic [16:0] far_raw, near_raw, now_raw;
	logic [16:0] far_t, near_t, now_t;
	logic        le_far, le_near, le_now;
	logic        can_speak;
	dat_index_t  idx;
	logic        new_man;
	logic        far_c, near_c, now_c;
	logic        fine;
	logic [23:0] rnd_sum;
	logic [25:0] recip;
	logic [49:0] rnd_prod;
	logic [16:0] rnd_q;
	logic [16:0] metres;

	// Speed clamp to 0..60 m/s
	always_comb begin
		if (item.speed_cmps[15]) begin
			speed = '0;
		end else if (item.speed_cmps[14:0] > {2'b00, SPEED_MAX}) begin
			speed = SPEED_MAX;
		end else begin
			speed = item.speed_cmps[12:0];
		end
	end

	// Thresholds: 20s, 8s, 2s as shift-adds, then clamped
	assign far_raw  = {speed, 4'b0} + {2'b00, speed, 2'b0};
	assign near_raw = {1'b0, speed, 3'b0};
	assign now_raw  = {3'b000, speed, 1'b0};

	always_comb begin
		far_t  = (far_raw < FAR_MIN) ? FAR_MIN : ((far_raw > FAR_MAX) ? FAR_MAX : far_raw);
		near_t = (near_raw < NEAR_MIN) ? NEAR_MIN :
			((near_raw > NEAR_MAX) ? NEAR_MAX : near_raw);
		now_t  = (now_raw < NOW_MIN) ? NOW_MIN : ((now_raw > NOW_MAX) ? NOW_MAX : now_raw);
	end

	assign le_far  = item.distance_cm <= $signed({7'd0, far_t});
	assign le_near = item.distance_cm <= $signed({7'd0, near_t});
	assign le_now  = item.distance_cm <= $signed({7'd0, now_t});

	// Rounding by reciprocal multiply; one multiplier shared by both step sizes
	assign fine     = item.distance_cm[22:0] < FINE_LIMIT[22:0];
	assign rnd_sum  = {1'b0, item.distance_cm[22:0]} + (fine ? FINE_HALF : COARSE_HALF);
	assign recip    = fine ? RECIP_FINE : RECIP_COARSE;
	assign rnd_prod = {26'd0, rnd_sum} * {24'd0, recip};
	assign rnd_q    = {2'b00, rnd_prod[49:RND_SHIFT]};

	always_comb begin
		if (item.distance_cm[23] || (item.distance_cm == '0)) begin
			metres = '0;
		end else if (fine) begin
			metres = 17'(rnd_q * FINE_METRES);
		end else begin
			metres = 17'(rnd_q * COARSE_METRES);
		end
	end

	// Maneuver tracking: a new index drops the distance flags
	assign can_speak = enable && item.speaker_ready;
	assign idx       = to_index(item.next_index);
	assign new_man   = !state_cur.have_current || (state_cur.current_index != idx);
	assign far_c     = new_man ? 1'b0 : state_cur.far_done;
	assign near_c    = new_man ? 1'b0 : state_cur.near_done;
	assign now_c     = new_man ? 1'b0 : state_cur.now_done;

	// Decision and next state
	always_comb begin
		state_nxt = state_cur;
		result    = '0;
		unique case (item.func)
			FUNC_RESET: begin
				state_nxt          = STATE_CLEAR;
				result.stop_speech = 1'b1;
			end
			FUNC_REROUTE: begin
				state_nxt = STATE_CLEAR;
				if (can_speak) begin
					result.spoke = 1'b1;
					result.kind  = KIND_REROUTE;
				end
			end
			FUNC_UPDATE: begin
				if (enable && item.nav_valid) begin
					if (item.nav_status == STATUS_ARRIVED) begin
						state_nxt.offroute_done = 1'b0;
						if (!state_cur.arrival_done && can_speak) begin
							state_nxt.arrival_done = 1'b1;
							result.spoke           = 1'b1;
							result.kind            = KIND_ARRIVED;
						end
					end else if (item.nav_status == STATUS_OFF_ROUTE) begin
						state_nxt.arrival_done = 1'b0;
						if (!state_cur.offroute_done && can_speak) begin
							state_nxt.offroute_done = 1'b1;
							result.spoke            = 1'b1;
							result.kind             = KIND_OFFROUTE;
						end
					end else begin
						state_nxt.arrival_done  = 1'b0;
						state_nxt.offroute_done = 1'b0;
						if (item.nav_status == STATUS_ON_ROUTE && item.next_found &&
								!item.next_is_arrive) begin
							state_nxt.have_current  = 1'b1;
							state_nxt.current_index = idx;
							state_nxt.far_done      = far_c;
							state_nxt.near_done     = near_c;
							state_nxt.now_done      = now_c;
							if (!state_cur.initial_done) begin
								// first announcement for the route
								if (can_speak) begin
									state_nxt.initial_done = 1'b1;
									state_nxt.far_done     = far_c | le_far;
									state_nxt.near_done    = near_c | le_near;
									state_nxt.now_done     = now_c | le_now;
									result.spoke           = 1'b1;
									result.announced_index = from_index(idx);
									if (le_now) begin
										result.kind = KIND_NOW;
									end else begin
										result.kind           = KIND_DIST;
										result.rounded_metres = metres;
									end
								end
							end else begin
								priority if (le_now && !now_c) begin
									if (can_speak) begin
										state_nxt.far_done     = 1'b1;
										state_nxt.near_done    = 1'b1;
										state_nxt.now_done     = 1'b1;
										result.spoke           = 1'b1;
										result.kind            = KIND_NOW;
										result.announced_index = from_index(idx);
									end
								end else if (le_near && !near_c) begin
									if (can_speak) begin
										state_nxt.far_done     = 1'b1;
										state_nxt.near_done    = 1'b1;
										result.spoke           = 1'b1;
										result.kind            = KIND_DIST;
										result.rounded_metres  = metres;
										result.announced_index = from_index(idx);
									end
								end else if (le_far && !far_c) begin
									if (can_speak) begin
										state_nxt.far_done     = 1'b1;
										result.spoke           = 1'b1;
										result.kind            = KIND_DIST;
										result.rounded_metres  = metres;
										result.announced_index = from_index(idx);
									end
								end else begin
									// nothing due
								end
							end
						end
					end
				end
			end
			default: begin
				// unused function code: empty result
			end
		endcase
	end

endmodule

// ----- hdl/distance_announcement_trigger_unit.sv -----
// Top level of the distance announcement trigger.
//
//  port       | dir  | transfer carries
//  -----------+------+------------------------------------------------
//  in_ch      | sink | one update, reroute or reset item
//  out_ch     | src  | one result per item (spoke, kind, metres, index)
//  cfg_we     | in   | guidance_enable write strobe, data on cfg_wdata
//
// One item per cycle sustained while out_ch is not stalled; an item is held
// in the input register, then its result in the result register.
// The decision and state update sit between the input register and the
// result register; the state is written when an item moves to the result.
// A stalled output holds its result while one more item waits in the input
// register; input ready drops only when both are full and output is stalled.
// arst_n clears valids, guidance_enable to 1 and the state; no clearing pass.
`include "distance_announcement_trigger_unit_assert.svh"

module distance_announcement_trigger_unit import dat_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_wdata,
	dat_in_if.sink    in_ch,
	dat_out_if.source out_ch
);

	logic       valid_s1;
	dat_in_t    item_s1;
	logic       out_valid_q;
	dat_out_t   result_q;
	logic       enable_q;
	dat_state_t state_q;
	dat_state_t state_nxt;
	dat_out_t   result_d;
	logic       advance;
	logic       in_xfer;
	logic       en_change;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_xfer      = in_ch.valid && in_ch.ready;
	assign en_change    = cfg_we && (cfg_wdata != enable_q);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_ch.payload;
		end
	end

	// Decision logic
	dat_decide u_decide (
		.item      (item_s1),
		.state_cur (state_q),
		.enable    (enable_q),
		.result    (result_d),
		.state_nxt (state_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = result_q;

	// Enable register and announcement state; an enable change clears state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			state_q  <= STATE_CLEAR;
		end else if (en_change) begin
			enable_q <= cfg_wdata;
			state_q  <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Checks
	`DAT_ASSERT_NOW(a_kind_matches_spoke, out_valid_q,
		result_q.spoke == (result_q.kind != KIND_NONE))
	`DAT_ASSERT_NOW(a_stop_is_silent, out_valid_q && result_q.stop_speech,
		!result_q.spoke)
	`DAT_ASSERT_NOW(a_metres_only_dist, out_valid_q && (result_q.rounded_metres != '0),
		result_q.kind == KIND_DIST)
	`DAT_ASSERT_NEXT(a_enable_change_clears, en_change, state_q == STATE_CLEAR)
	`DAT_ASSERT_NEXT(a_stall_holds_item, valid_s1 && !advance, valid_s1 && $stable(item_s1))

endmodule

// ----- sim/distance_announcement_trigger_unit_tb.sv -----
// Self-checking testbench for the distance announcement trigger unit.
`timescale 1ns / 1ps

module distance_announcement_trigger_unit_tb;
	import dat_pkg::*;

	// Codes with no name in the package
	localparam logic [1:0] FUNC_SPARE   = 2'd3;
	localparam logic [1:0] STATUS_OTHER = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_GAP     = 17;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dat_in_if  in_ch();
	dat_out_if out_ch();

	distance_announcement_trigger_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Predictor state and expected announcements
	logic       guidance_on;
	dat_state_t guide_state;
	dat_out_t   announce_q[$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  sent_items = 0;
	int  hold_off_cycles = 0;
	int  next_gap = 0;
	bit  offering = 1'b0;
	bit  in_steady = 1'b0;
	bit  out_steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// 10 m steps below 100 m, 50 m steps from 100 m up, half rounds up
	function automatic logic [16:0] round_to_step(input int d);
		int step;
		int m;
		if (d <= 0) return '0;
		step = (d < 10000) ? 1000 : 5000;
		m = ((d + step / 2) / step) * (step / 100);
		return m[16:0];
	endfunction

	function automatic void clear_guidance();
		guide_state = STATE_CLEAR;
	endfunction

	// Expected result of one item; advances the predictor state
	function automatic dat_out_t predict_announcement(input dat_in_t it);
		dat_out_t r;
		int dist_cm;
		int spd;
		int far_t;
		int near_t;
		int now_t;
		bit talk;
		dat_index_t idx;
		r = '0;
		talk = guidance_on && it.speaker_ready;
		dist_cm = {{8{it.distance_cm[23]}}, it.distance_cm};
		spd = clamp_int({{16{it.speed_cmps[15]}}, it.speed_cmps}, 0, 6000);
		idx = to_index(it.next_index);

		if (it.func == FUNC_RESET) begin
			clear_guidance();
			r.stop_speech = 1'b1;
			return r;
		end
		if (it.func == FUNC_REROUTE) begin
			clear_guidance();
			if (talk) begin
				r.spoke = 1'b1;
				r.kind = KIND_REROUTE;
			end
			return r;
		end
		if (it.func != FUNC_UPDATE || !guidance_on || !it.nav_valid) return r;

		// Arrival and off-route flags
		if (it.nav_status == STATUS_ARRIVED) begin
			guide_state.offroute_done = 1'b0;
			if (!guide_state.arrival_done && talk) begin
				guide_state.arrival_done = 1'b1;
				r.spoke = 1'b1;
				r.kind = KIND_ARRIVED;
			end
			return r;
		end
		guide_state.arrival_done = 1'b0;
		if (it.nav_status == STATUS_OFF_ROUTE) begin
			if (!guide_state.offroute_done && talk) begin
				guide_state.offroute_done = 1'b1;
				r.spoke = 1'b1;
				r.kind = KIND_OFFROUTE;
			end
			return r;
		end
		guide_state.offroute_done = 1'b0;
		if (it.nav_status != STATUS_ON_ROUTE || !it.next_found || it.next_is_arrive) return r;

		// New maneuver restarts the once-only flags
		if (!guide_state.have_current || guide_state.current_index != idx) begin
			guide_state.have_current = 1'b1;
			guide_state.current_index = idx;
			guide_state.far_done = 1'b0;
			guide_state.near_done = 1'b0;
			guide_state.now_done = 1'b0;
		end

		far_t = clamp_int(spd * 20, 20000, 60000);
		near_t = clamp_int(spd * 8, 6000, 18000);
		now_t = clamp_int(spd * 2, 2000, 4500);

		// First maneuver announcement of the trip
		if (!guide_state.initial_done) begin
			if (!talk) return r;
			guide_state.initial_done = 1'b1;
			if (dist_cm <= far_t) guide_state.far_done = 1'b1;
			if (dist_cm <= near_t) guide_state.near_done = 1'b1;
			r.spoke = 1'b1;
			r.announced_index = from_index(idx);
			if (dist_cm <= now_t) begin
				guide_state.now_done = 1'b1;
				r.kind = KIND_NOW;
			end else begin
				r.kind = KIND_DIST;
				r.rounded_metres = round_to_step(dist_cm);
			end
			return r;
		end

		// Threshold crossings, closest first
		if (dist_cm <= now_t && !guide_state.now_done) begin
			if (!talk) return r;
			guide_state.far_done = 1'b1;
			guide_state.near_done = 1'b1;
			guide_state.now_done = 1'b1;
			r.spoke = 1'b1;
			r.kind = KIND_NOW;
			r.announced_index = from_index(idx);
		end else if (dist_cm <= near_t && !guide_state.near_done) begin
			if (!talk) return r;
			guide_state.far_done = 1'b1;
			guide_state.near_done = 1'b1;
			r.spoke = 1'b1;
			r.kind = KIND_DIST;
			r.rounded_metres = round_to_step(dist_cm);
			r.announced_index = from_index(idx);
		end else if (dist_cm <= far_t && !guide_state.far_done) begin
			if (!talk) return r;
			guide_state.far_done = 1'b1;
			r.spoke = 1'b1;
			r.kind = KIND_DIST;
			r.rounded_metres = round_to_step(dist_cm);
			r.announced_index = from_index(idx);
		end
		return r;
	endfunction

	function automatic dat_in_t build_item(input logic [1:0] func, input bit nav_valid,
			input logic [1:0] status, input bit found, input bit is_arrive, input int idx,
			input int dist_cm, input int spd, input bit ready);
		dat_in_t it;
		it.func = func;
		it.nav_valid = nav_valid;
		it.nav_status = status;
		it.next_found = found;
		it.next_is_arrive = is_arrive;
		it.next_index = idx[15:0];
		it.distance_cm = dist_cm[23:0];
		it.speed_cmps = spd[15:0];
		it.speaker_ready = ready;
		return it;
	endfunction

	// Mix of short gaps, long gaps and no-gap stretches
	function automatic int draw_gap(input bit steady);
		if (steady) return 0;
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_GAP);
		return $urandom_range(0, 2);
	endfunction

	// One input transfer; valid stays high when the next item follows at once
	task automatic send_item(input dat_in_t it);
		if (!offering) repeat (next_gap) @(posedge clk);
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		offering = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		announce_q.push_back(predict_announcement(it));
		sent_items++;
		if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
		next_gap = draw_gap(in_steady);
		if (next_gap > 0) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Stop offering and wait for every expected result
	task automatic wait_for_quiet();
		if (offering) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		while (announce_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_guidance(input bit en);
		wait_for_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (en != guidance_on) begin
			guidance_on = en;
			clear_guidance();
		end
	endtask

	// Result side: random stalls plus requested long hold-offs
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
			stall = draw_gap(out_steady);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid && hold_off_cycles == 0);
		end
	end

	// Result checker
	always @(posedge clk) begin
		dat_out_t want;
		dat_out_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (announce_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: spoke %0d kind %0d metres %0d index %0d stop %0d",
						got.spoke, got.kind, got.rounded_metres, got.announced_index,
						got.stop_speech);
			end else begin
				want = announce_q.pop_front();
				if (got.spoke !== want.spoke || got.kind !== want.kind ||
						got.rounded_metres !== want.rounded_metres ||
						got.announced_index !== want.announced_index ||
						got.stop_speech !== want.stop_speech) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected spoke %0d kind %0d metres %0d index %0d stop %0d",
							want.spoke, want.kind, want.rounded_metres, want.announced_index,
							want.stop_speech);
						$display("          actual   spoke %0d kind %0d metres %0d index %0d stop %0d",
							got.spoke, got.kind, got.rounded_metres, got.announced_index,
							got.stop_speech);
					end
				end
			end
		end
	end

	// Field extremes, every function and each corner of the decision
	task automatic test_directed();
		send_item(build_item(FUNC_SPARE, 1, STATUS_ON_ROUTE, 1, 0, 16'h1234, 1000, 500, 1));
		send_item(build_item(FUNC_RESET, 1, STATUS_ON_ROUTE, 1, 0, 0, 0, 0, 1));
		send_item(build_item(FUNC_UPDATE, 0, STATUS_ON_ROUTE, 1, 0, 5, 1000, 500, 1));
		// first announcement far out, then far, near and now crossings
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 0, 8388607, 32767, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 0, 60000, 32767, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 0, 18000, 32767, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 0, 4500, 32767, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 0, 0, 32767, 1));
		// index change recorded while the speaker refuses
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 65535, -8388608, -32768, 0));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 65535, -8388608, -32768, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_OTHER, 1, 0, 65535, 100, 0, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 0, 0, 3, 100, 0, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 1, 3, 100, 0, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ARRIVED, 1, 1, 3, 0, 0, 0));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ARRIVED, 1, 1, 3, 0, 0, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ARRIVED, 1, 1, 3, 0, 0, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_OFF_ROUTE, 1, 0, 3, 0, 0, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_OFF_ROUTE, 1, 0, 3, 0, 0, 1));
		send_item(build_item(FUNC_REROUTE, 1, STATUS_ON_ROUTE, 1, 0, 3, 0, 0, 1));
		send_item(build_item(FUNC_REROUTE, 1, STATUS_ON_ROUTE, 1, 0, 3, 0, 0, 0));
		// rounding around 100 m
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 7, 9499, 0, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 8, 9500, 3000, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 9, 10000, 1000, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 10, 12499, 1000, 1));
		send_item(build_item(FUNC_RESET, 1, STATUS_ON_ROUTE, 1, 0, 10, 0, 0, 1));
	endtask

	// Disabled guidance, a rewrite of the same value, then back on
	task automatic test_guidance_toggle();
		set_guidance(1'b0);
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 4, 50000, 1500, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ARRIVED, 1, 0, 4, 0, 1500, 1));
		send_item(build_item(FUNC_REROUTE, 1, STATUS_ON_ROUTE, 1, 0, 4, 0, 0, 1));
		send_item(build_item(FUNC_RESET, 1, STATUS_ON_ROUTE, 1, 0, 4, 0, 0, 1));
		set_guidance(1'b0);
		send_item(build_item(FUNC_UPDATE, 1, STATUS_OFF_ROUTE, 1, 0, 4, 0, 0, 1));
		set_guidance(1'b1);
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 4, 50000, 1500, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 4, 15000, 1500, 1));
		set_guidance(1'b1);
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 4, 2500, 1500, 1));
		// change mid-maneuver clears the flags
		set_guidance(1'b0);
		set_guidance(1'b1);
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 4, 2500, 1500, 1));
	endtask

	// One trip toward a maneuver with random disturbances, then arrival
	task automatic drive_route();
		dat_in_t it;
		int idx;
		int dist_cm;
		int spd;
		int neg;
		idx = $urandom_range(0, 65535);
		dist_cm = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8388607)
			: $urandom_range(500, 900000);
		spd = $urandom_range(0, 6500);
		while (dist_cm > -3000) begin
			it = build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, idx, dist_cm, spd,
				$urandom_range(0, 7) != 0);
			case ($urandom_range(0, 39))
				0: it.nav_status = STATUS_OFF_ROUTE;
				1: it.nav_status = STATUS_OTHER;
				2: it.nav_valid = 1'b0;
				3: it.next_found = 1'b0;
				4: begin
					idx = $urandom_range(0, 65535);
					it.next_index = idx[15:0];
				end
				5: it.func = FUNC_REROUTE;
				6: begin
					neg = -int'($urandom_range(1, 32768));
					it.speed_cmps = neg[15:0];
				end
				7: it.next_is_arrive = 1'b1;
				default: ;
			endcase
			send_item(it);
			if ($urandom_range(0, 3) == 0) dist_cm = dist_cm - int'($urandom_range(0, 1000));
			else dist_cm = dist_cm - int'($urandom_range(500, (dist_cm > 100000) ? 60000 : 8000));
			spd = clamp_int(spd + int'($urandom_range(0, 600)) - 300, 0, 6500);
		end
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 1, idx, 0, spd, 1));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ARRIVED, 1, 1, idx, 0, 0,
			$urandom_range(0, 3) != 0));
		send_item(build_item(FUNC_UPDATE, 1, STATUS_ARRIVED, 1, 1, idx, 0, 0, 1));
		if ($urandom_range(0, 1) == 0)
			send_item(build_item(FUNC_RESET, 1, STATUS_ON_ROUTE, 1, 0, idx, 0, 0, 1));
	endtask

	// Routes in phases, with the register changed between phases
	task automatic test_routes();
		int phase;
		for (phase = 0; phase < 4; phase++) begin
			while (sent_items < 150 * (phase + 1) + 40) drive_route();
			set_guidance(phase == 1 ? 1'b0 : 1'b1);
		end
	endtask

	// Unstructured items over the full range of every field
	task automatic test_noise();
		dat_in_t it;
		int n;
		for (n = 0; n < 300; n++) begin
			it = dat_in_t'({$urandom, $urandom});
			it.func = 2'($urandom_range(0, 3));
			send_item(it);
			if (n == 150) set_guidance(1'($urandom_range(0, 1)));
		end
		set_guidance(1'b1);
	endtask

	// Long result stall fills the block; then the sender waits for all results
	task automatic test_backpressure();
		int n;
		hold_off_cycles = 60;
		for (n = 0; n < 12; n++)
			send_item(build_item(FUNC_UPDATE, 1, STATUS_ON_ROUTE, 1, 0, 77,
				40000 - n * 3500, 2000, 1));
		wait_for_quiet();
		hold_off_cycles = 45;
		repeat (3) drive_route();
		wait_for_quiet();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		guidance_on = 1'b1;
		clear_guidance();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_guidance_toggle();
		test_routes();
		test_noise();
		test_backpressure();

		wait_for_quiet();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && announce_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
